// File: rtl/core/ierq_pkg.sv
// ----------------------------------------------------------------------------
// Input event ring queue package
// Shared constants, event codes and ring control types for the event queue.
// ----------------------------------------------------------------------------
package ierq_pkg;

  localparam int unsigned QUEUE_DEPTH = 512;
  localparam int unsigned MS_PER_SEC  = 1000;

  localparam int TIME_W   = 40;
  localparam int EVENT_W  = 50;
  localparam int WORD_W   = TIME_W + EVENT_W;
  localparam int SEC_W    = 31;
  localparam int USEC_W   = 20;
  localparam int REM_W    = 10;
  localparam int DIV_STEP = 4;
  localparam int DIV_ITERS = TIME_W / DIV_STEP;

  localparam logic [1:0] ACT_KEY   = 2'd0;
  localparam logic [1:0] ACT_MOUSE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DROPPED = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;

  localparam logic [1:0] EV_SYN = 2'd0;
  localparam logic [1:0] EV_KEY = 2'd1;
  localparam logic [1:0] EV_REL = 2'd2;

  localparam logic [15:0] SYNC_MARK     = 16'h0000;
  localparam logic [15:0] REL_X         = 16'h0000;
  localparam logic [15:0] REL_Y         = 16'h0001;
  localparam logic [15:0] REL_Z         = 16'h0002;
  localparam logic [15:0] LEFT_BUTTON   = 16'h0110;
  localparam logic [15:0] RIGHT_BUTTON  = 16'h0111;
  localparam logic [15:0] MIDDLE_BUTTON = 16'h0112;

  typedef struct packed {
    logic push;
    logic pop;
    logic rd_en;
  } ring_cmd_t;

endpackage

// File: rtl/core/ierq_ring.sv
// ----------------------------------------------------------------------------
// Event ring
// One event ring: a memory of time and event words, with one write and one read
// port, and write and read pointers. A push into a full ring drops the oldest item.
// ----------------------------------------------------------------------------
module ierq_ring #(
  parameter int DEPTH = ierq_pkg::QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ierq_pkg::ring_cmd_t         cmd,
  input  logic [ierq_pkg::WORD_W-1:0] wdata,
  output logic [ierq_pkg::WORD_W-1:0] rdata,
  output logic                        empty,
  output logic [PTR_W-1:0]            free
);

  localparam int CW = PTR_W + 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [ierq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr;
  logic [PTR_W-1:0] rd;
  logic [PTR_W-1:0] wr_inc;
  logic [PTR_W-1:0] rd_inc;
  logic [CW-1:0]    free_ext;

  assign wr_inc = (wr == LAST) ? '0 : wr + 1'b1;
  assign rd_inc = (rd == LAST) ? '0 : rd + 1'b1;
  assign empty  = (wr == rd);

  always_comb begin
    free_ext = {1'b0, rd} - {1'b0, wr} - CW'(1);
    if (rd <= wr) begin
      free_ext = free_ext + DEPTH_C;
    end
  end

  assign free = free_ext[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
    end else begin
      if (cmd.push) begin
        wr <= wr_inc;
        if (wr_inc == rd) begin
          rd <= rd_inc;
        end
      end else if (cmd.pop) begin
        rd <= rd_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd];
    end
  end

endmodule

// File: rtl/core/ierq_msdiv.sv
// ----------------------------------------------------------------------------
// Timestamp divider
// Iterative division of a millisecond count by 1000, four quotient bits per
// cycle, giving seconds and microseconds.
// ----------------------------------------------------------------------------
module ierq_msdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ierq_pkg::TIME_W-1:0] dividend,
  output logic                        done,
  output logic [ierq_pkg::SEC_W-1:0]  sec,
  output logic [ierq_pkg::USEC_W-1:0] usec
);

  localparam int TW = ierq_pkg::TIME_W;
  localparam int RW = ierq_pkg::REM_W;
  localparam int CNT_W = $clog2(ierq_pkg::DIV_ITERS + 1);
  localparam logic [RW:0] DIVISOR = (RW + 1)'(ierq_pkg::MS_PER_SEC);

  logic [TW-1:0]    quo;
  logic [RW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [TW-1:0]    quo_next;
  logic [RW-1:0]    rem_next;
  logic [RW:0]      trial;

  always_comb begin
    quo_next = quo;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < ierq_pkg::DIV_STEP; i++) begin
      trial = {rem_next, quo_next[TW-1]};
      if (trial >= DIVISOR) begin
        trial    = trial - DIVISOR;
        quo_next = {quo_next[TW-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[TW-2:0], 1'b0};
      end
      rem_next = trial[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ierq_pkg::DIV_ITERS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (run) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign sec  = quo[ierq_pkg::SEC_W-1:0];
  assign usec = ierq_pkg::USEC_W'(rem) * ierq_pkg::USEC_W'(ierq_pkg::MS_PER_SEC);

endmodule

// File: rtl/core/input_event_ring_queue_top.sv
// ----------------------------------------------------------------------------
// Input event ring queue
// Keyboard and mouse event rings with packet drop, overwrite and timed reads.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and each item gives
// exactly one result, shown for a single cycle with done high; the receiver
// cannot stall it, so it must capture the result in that cycle. A key report
// makes two ring writes, a mouse report a check step, then seven write slots
// on the mouse ring's write port, or only the check if dropped; a read of an
// empty ring ends after its check, and any other read checks, loads, then waits
// for the timestamp divider that retires four quotient bits per cycle.
module input_event_ring_queue_top #(
  parameter int QUEUE_DEPTH = ierq_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic                        device,
  input  logic [15:0]                 key_code,
  input  logic signed [31:0]          key_value,
  input  logic signed [15:0]          move_x,
  input  logic signed [15:0]          move_y,
  input  logic signed [7:0]           wheel,
  input  logic [2:0]                  buttons,
  input  logic [ierq_pkg::TIME_W-1:0] now_ms,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [ierq_pkg::SEC_W-1:0]  ev_sec,
  output logic [ierq_pkg::USEC_W-1:0] ev_usec,
  output logic [1:0]                  ev_type,
  output logic [15:0]                 ev_code,
  output logic signed [31:0]          ev_value
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CMP_W = (PTR_W > 3) ? PTR_W : 3;
  localparam int WW = ierq_pkg::WORD_W;
  localparam int EW = ierq_pkg::EVENT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KEY1  = 3'd1;
  localparam logic [2:0] S_KEY2  = 3'd2;
  localparam logic [2:0] S_MCHK  = 3'd3;
  localparam logic [2:0] S_MPUSH = 3'd4;
  localparam logic [2:0] S_RDCHK = 3'd5;
  localparam logic [2:0] S_RDLD  = 3'd6;
  localparam logic [2:0] S_DIV   = 3'd7;

  localparam logic [2:0] PH_X      = 3'd0;
  localparam logic [2:0] PH_Y      = 3'd1;
  localparam logic [2:0] PH_Z      = 3'd2;
  localparam logic [2:0] PH_LEFT   = 3'd3;
  localparam logic [2:0] PH_RIGHT  = 3'd4;
  localparam logic [2:0] PH_MIDDLE = 3'd5;
  localparam logic [2:0] PH_SYN    = 3'd6;

  logic [2:0]                  state;
  logic [2:0]                  phase;
  logic [1:0]                  act;
  logic                        dev;
  logic [15:0]                 kcode;
  logic [31:0]                 kval;
  logic [15:0]                 mx;
  logic [15:0]                 my;
  logic [7:0]                  mwheel;
  logic [2:0]                  mbtn;
  logic [ierq_pkg::TIME_W-1:0] ms;
  logic [2:0]                  last_buttons;
  logic [1:0]                  etype;
  logic [15:0]                 ecode;
  logic [31:0]                 evalue;

  ierq_pkg::ring_cmd_t kbd_cmd;
  ierq_pkg::ring_cmd_t mouse_cmd;
  logic [WW-1:0]       wdata;
  logic [EW-1:0]       wevent;
  logic [WW-1:0]       kbd_rdata;
  logic [WW-1:0]       mouse_rdata;
  logic [WW-1:0]       sel_rdata;
  logic                kbd_empty;
  logic                mouse_empty;
  logic [PTR_W-1:0]    kbd_free;
  logic [PTR_W-1:0]    mouse_free;
  logic [2:0]          changed;
  logic [6:0]          need_vec;
  logic [2:0]          need_cnt;
  logic                no_room;
  logic                div_start;
  logic                div_done;
  logic [ierq_pkg::SEC_W-1:0]  div_sec;
  logic [ierq_pkg::USEC_W-1:0] div_usec;

  assign busy    = (state != S_IDLE);
  assign changed = mbtn ^ last_buttons;
  assign need_vec = {1'b1, changed, (mwheel != 8'd0), (my != 16'd0), (mx != 16'd0)};
  assign need_cnt = 3'($countones(need_vec));
  assign no_room  = CMP_W'(mouse_free) < CMP_W'(need_cnt);
  assign sel_rdata = dev ? mouse_rdata : kbd_rdata;
  assign div_start = (state == S_RDLD);

  always_comb begin
    case (state)
      S_KEY1: wevent = {ierq_pkg::EV_KEY, kcode, kval};
      S_KEY2: wevent = {ierq_pkg::EV_SYN, ierq_pkg::SYNC_MARK, 32'd0};
      default: begin
        case (phase)
          PH_X:      wevent = {ierq_pkg::EV_REL, ierq_pkg::REL_X, {{16{mx[15]}}, mx}};
          PH_Y:      wevent = {ierq_pkg::EV_REL, ierq_pkg::REL_Y, {{16{my[15]}}, my}};
          PH_Z:      wevent = {ierq_pkg::EV_REL, ierq_pkg::REL_Z,
                               {{24{mwheel[7]}}, mwheel}};
          PH_LEFT:   wevent = {ierq_pkg::EV_KEY, ierq_pkg::LEFT_BUTTON, 31'd0, mbtn[0]};
          PH_RIGHT:  wevent = {ierq_pkg::EV_KEY, ierq_pkg::RIGHT_BUTTON, 31'd0, mbtn[1]};
          PH_MIDDLE: wevent = {ierq_pkg::EV_KEY, ierq_pkg::MIDDLE_BUTTON, 31'd0, mbtn[2]};
          default:   wevent = {ierq_pkg::EV_SYN, ierq_pkg::SYNC_MARK, 32'd0};
        endcase
      end
    endcase
  end

  assign wdata = {ms, wevent};

  always_comb begin
    kbd_cmd   = '0;
    mouse_cmd = '0;
    case (state)
      S_KEY1, S_KEY2: kbd_cmd.push = 1'b1;
      S_MPUSH: mouse_cmd.push = need_vec[phase];
      S_RDCHK: begin
        if (dev && !mouse_empty) begin
          mouse_cmd.rd_en = 1'b1;
          mouse_cmd.pop   = 1'b1;
        end else if (!dev && !kbd_empty) begin
          kbd_cmd.rd_en = 1'b1;
          kbd_cmd.pop   = 1'b1;
        end
      end
      default: begin
        kbd_cmd   = '0;
        mouse_cmd = '0;
      end
    endcase
  end

  ierq_ring #(.DEPTH(QUEUE_DEPTH)) u_kbd_ring (
    .clk   (clk),
    .rst   (rst),
    .cmd   (kbd_cmd),
    .wdata (wdata),
    .rdata (kbd_rdata),
    .empty (kbd_empty),
    .free  (kbd_free)
  );

  ierq_ring #(.DEPTH(QUEUE_DEPTH)) u_mouse_ring (
    .clk   (clk),
    .rst   (rst),
    .cmd   (mouse_cmd),
    .wdata (wdata),
    .rdata (mouse_rdata),
    .empty (mouse_empty),
    .free  (mouse_free)
  );

  ierq_msdiv u_msdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sel_rdata[WW-1:EW]),
    .done     (div_done),
    .sec      (div_sec),
    .usec     (div_usec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_X;
      last_buttons <= 3'd0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (action)
              ierq_pkg::ACT_KEY:   state <= S_KEY1;
              ierq_pkg::ACT_MOUSE: state <= S_MCHK;
              ierq_pkg::ACT_READ:  state <= S_RDCHK;
              default:             done  <= 1'b1;
            endcase
          end
        end
        S_KEY1: state <= S_KEY2;
        S_KEY2: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        S_MCHK: begin
          phase <= PH_X;
          if (no_room) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_MPUSH;
          end
        end
        S_MPUSH: begin
          phase <= phase + 1'b1;
          if (phase == PH_SYN) begin
            last_buttons <= mbtn;
            state        <= S_IDLE;
            done         <= 1'b1;
          end
        end
        S_RDCHK: begin
          if (dev ? mouse_empty : kbd_empty) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_RDLD;
          end
        end
        S_RDLD: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      act    <= action;
      dev    <= device;
      kcode  <= key_code;
      kval   <= key_value;
      mx     <= move_x;
      my     <= move_y;
      mwheel <= wheel;
      mbtn   <= buttons;
      ms     <= now_ms;
    end
    if (state == S_RDLD) begin
      etype  <= sel_rdata[EW-1:EW-2];
      ecode  <= sel_rdata[EW-3:32];
      evalue <= sel_rdata[31:0];
    end
  end

  always_ff @(posedge clk) begin
    status   <= ierq_pkg::STAT_OK;
    ev_sec   <= '0;
    ev_usec  <= '0;
    ev_type  <= ierq_pkg::EV_SYN;
    ev_code  <= 16'd0;
    ev_value <= 32'sd0;
    if (state == S_MCHK && no_room) begin
      status <= ierq_pkg::STAT_DROPPED;
    end
    if (state == S_RDCHK && (dev ? mouse_empty : kbd_empty)) begin
      status <= ierq_pkg::STAT_EMPTY;
    end
    if (state == S_DIV && div_done && act == ierq_pkg::ACT_READ) begin
      ev_sec   <= div_sec;
      ev_usec  <= div_usec;
      ev_type  <= etype;
      ev_code  <= ecode;
      ev_value <= evalue;
    end
  end

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy dropped without a result");

  a_div_done_in_read: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside a read");

  a_key_ring_filled: assert property (@(posedge clk) disable iff (rst)
    (state == S_KEY2) |-> !kbd_empty)
    else $error("keyboard ring empty after a key push");

endmodule
